>>> rtl/uart_rb_pkg.sv
// ----------------------------------------------------------------------------
// UART ring buffer package
// Operation codes, default ring size and the stage-one flag record shared by
// the ring buffer unit.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

	// Default number of positions in each ring (one is always kept free).
	localparam int unsigned SLOTS_DEF = 64;

	localparam int unsigned OP_W = 2;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [7:0]      byte_t;

	localparam op_t OP_HOST_WRITE = 2'd0;
	localparam op_t OP_TX_READY   = 2'd1;
	localparam op_t OP_RX_BYTE    = 2'd2;
	localparam op_t OP_HOST_READ  = 2'd3;

	// Outcome of one request, decided in the accept cycle from the pointers.
	typedef struct packed {
		logic write_failed;
		logic tx_kick;
		logic line_out_valid;
		logic read_valid;
		logic rx_dropped;
	} flags_t;

endpackage

>>> rtl/uart_tx_rx_ring_buffers_unit.sv
// ----------------------------------------------------------------------------
// UART transmit / receive ring buffer unit
// Two byte rings in synchronous memories with wrap-around pointers, plus a
// transmit-active flag, driven by one operation per request.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle and returns exactly one result
// per request, in order. Each request is decided in the cycle it is accepted:
// the pointers are compared, the ring memory is written or read at the edge
// of acceptance and the pointers move at that same edge. The registered memory
// read data waits with its request in the read stage and is formed into the
// output register whenever that register is free or drains. The throughput
// is set by the single access to each ring memory per request, which is one
// per cycle; the request side stalls only while a result is held back by the
// downstream stall and another one is already in the read stage. Each ring
// has SLOTS positions and holds at most SLOTS-1 bytes; one position stays
// free so that full and empty can be told apart.
// A host write into a full transmit ring is reported with write_failed, and a
// host write that finds the transmitter idle makes it active and raises
// tx_kick. A transmitter-ready request pops the next byte for the line or,
// with an empty ring, sets the transmitter idle. Received bytes that find the
// receive ring full are dropped and reported with rx_dropped. A host read of
// an empty receive ring returns read_valid low and a zero byte. Every result
// field that does not belong to the request's operation is zero. The ring
// memories need no clearing after reset: a byte is only ever popped from a
// position that an earlier push wrote.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers_unit
	import uart_rb_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// Request channel
	input  logic       req_valid,
	output logic       req_stall,
	input  op_t        op,
	input  byte_t      data_byte,
	// Result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic       write_failed,
	output logic       tx_kick,
	output logic       line_out_valid,
	output byte_t      line_out_byte,
	output logic       read_valid,
	output byte_t      read_byte,
	output logic       rx_dropped
);

	localparam int unsigned PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(SLOTS - 1);

	typedef logic [PTR_W-1:0] ptr_t;

	function automatic ptr_t ring_next(input ptr_t pos);
		ring_next = (pos == LAST_POS) ? '0 : pos + PTR_W'(1);
	endfunction

	// Pointer and transmitter state.
	ptr_t tx_wr_q, tx_rd_q, rx_wr_q, rx_rd_q;
	logic sending_q;

	// Ring memories and their registered read data.
	byte_t tx_mem [SLOTS];
	byte_t rx_mem [SLOTS];
	byte_t tx_dout_q, rx_dout_q;

	// Read stage: one request waiting for its memory read data.
	logic   valid_s1;
	flags_t flags_s1;

	// Output register.
	logic   res_valid_q;
	flags_t res_flags_q;
	byte_t  line_byte_q, read_byte_q;

	logic   advance, accept;
	logic   tx_full, tx_empty, rx_full, rx_empty;
	logic   tx_push, tx_pop, rx_push, rx_pop;
	flags_t flags_d;

	// The read stage moves on whenever the output register is free or drains.
	assign advance   = !res_valid_q || !res_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	assign tx_full  = (ring_next(tx_wr_q) == tx_rd_q);
	assign tx_empty = (tx_wr_q == tx_rd_q);
	assign rx_full  = (ring_next(rx_wr_q) == rx_rd_q);
	assign rx_empty = (rx_wr_q == rx_rd_q);

	assign tx_push = accept && (op == OP_HOST_WRITE) && !tx_full;
	assign tx_pop  = accept && (op == OP_TX_READY)   && !tx_empty;
	assign rx_push = accept && (op == OP_RX_BYTE)    && !rx_full;
	assign rx_pop  = accept && (op == OP_HOST_READ)  && !rx_empty;

	always_comb begin
		flags_d = '0;
		case (op)
			OP_HOST_WRITE: begin
				flags_d.write_failed = tx_full;
				flags_d.tx_kick      = !tx_full && !sending_q;
			end
			OP_TX_READY: begin
				flags_d.line_out_valid = !tx_empty;
			end
			OP_RX_BYTE: begin
				flags_d.rx_dropped = rx_full;
			end
			OP_HOST_READ: begin
				flags_d.read_valid = !rx_empty;
			end
			default: begin
				flags_d = '0;
			end
		endcase
	end

	// Pointers and the transmit-active flag move at the accept edge, so the
	// next request already sees the updated rings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_q   <= '0;
			tx_rd_q   <= '0;
			rx_wr_q   <= '0;
			rx_rd_q   <= '0;
			sending_q <= 1'b0;
		end else begin
			if (tx_push) begin
				tx_wr_q   <= ring_next(tx_wr_q);
				sending_q <= 1'b1;
			end
			if (tx_pop) begin
				tx_rd_q <= ring_next(tx_rd_q);
			end
			if (accept && (op == OP_TX_READY) && tx_empty) begin
				sending_q <= 1'b0;
			end
			if (rx_push) begin
				rx_wr_q <= ring_next(rx_wr_q);
			end
			if (rx_pop) begin
				rx_rd_q <= ring_next(rx_rd_q);
			end
		end
	end

	// Transmit ring memory. A pop never targets the entry written in the same
	// cycle, since one request is either a push or a pop.
	always_ff @(posedge clk) begin
		if (tx_push) begin
			tx_mem[tx_wr_q] <= data_byte;
		end
		if (tx_pop) begin
			tx_dout_q <= tx_mem[tx_rd_q];
		end
	end

	// Receive ring memory.
	always_ff @(posedge clk) begin
		if (rx_push) begin
			rx_mem[rx_wr_q] <= data_byte;
		end
		if (rx_pop) begin
			rx_dout_q <= rx_mem[rx_rd_q];
		end
	end

	// Read stage control. The memory read data registers hold while the
	// stage waits, because no further pop can be accepted meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags_d;
		end
	end

	// Output register: fields that do not belong to the operation read zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_flags_q <= flags_s1;
			line_byte_q <= flags_s1.line_out_valid ? tx_dout_q : '0;
			read_byte_q <= flags_s1.read_valid ? rx_dout_q : '0;
		end
	end

	assign res_valid      = res_valid_q;
	assign write_failed   = res_flags_q.write_failed;
	assign tx_kick        = res_flags_q.tx_kick;
	assign line_out_valid = res_flags_q.line_out_valid;
	assign line_out_byte  = line_byte_q;
	assign read_valid     = res_flags_q.read_valid;
	assign read_byte      = read_byte_q;
	assign rx_dropped     = res_flags_q.rx_dropped;

	// A result reports at most one event.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({write_failed, tx_kick, line_out_valid,
			read_valid, rx_dropped}))
		else $error("result reports more than one event");

	// Bytes without their valid flag read zero.
	a_zero_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((line_out_valid || line_out_byte == '0) &&
			(read_valid || read_byte == '0)))
		else $error("byte field not zero without its valid flag");

	// A write into a full transmit ring leaves the write pointer alone.
	a_tx_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_HOST_WRITE && tx_full) |=> $stable(tx_wr_q))
		else $error("transmit write pointer moved on a full ring");

	// A host read of an empty receive ring leaves the read pointer alone.
	a_rx_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_HOST_READ && rx_empty) |=> $stable(rx_rd_q))
		else $error("receive read pointer moved on an empty ring");

	// A request waiting in the read stage is never overwritten.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> req_stall)
		else $error("request accepted while read stage is blocked");

endmodule

>>> tb/tb_uart_tx_rx_ring_buffers_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART ring buffer unit testbench
// Drives a short directed sequence, then operation requests in random bursts,
// and stalls the result channel on its own pattern. A scoreboard keeps a model
// of both rings and checks every result against it, in order.
// ----------------------------------------------------------------------------
module tb_uart_tx_rx_ring_buffers_unit;
	import uart_rb_pkg::*;

	localparam int unsigned SLOTS = SLOTS_DEF;

	// Length of the receiver's one-time hold-off, so that the unit fills up.
	localparam int unsigned HOLD_CYCLES = 300;

	// Length of an idle stretch, without any accepted request or result, at which the run is abandoned.
	localparam int unsigned IDLE_LIMIT = 4000;

	localparam int unsigned RANDOM_ITEMS = 750;

	// One result as it appears on the result channel.
	typedef struct packed {
		logic  write_failed;
		logic  tx_kick;
		logic  line_out_valid;
		byte_t line_out_byte;
		logic  read_valid;
		byte_t read_byte;
		logic  rx_dropped;
	} ring_result_t;

	// Traffic shapes for the random part. The fill and drain shapes push the
	// rings to their full and empty limits, the mixed shape stirs everything.
	typedef enum int {
		TRAFFIC_MIXED,
		TRAFFIC_TX_FILL,
		TRAFFIC_TX_DRAIN,
		TRAFFIC_RX_FILL,
		TRAFFIC_RX_DRAIN
	} traffic_t;

	// The scoreboard holds its own copy of both rings, their pointers and the
	// transmit-active flag. Each accepted request is turned into one expected
	// result, and results from the unit are matched against the oldest one.
	class ring_scoreboard;
		byte_t        tx_ring[SLOTS];
		byte_t        rx_ring[SLOTS];
		int unsigned  tx_wr;
		int unsigned  tx_rd;
		int unsigned  rx_wr;
		int unsigned  rx_rd;
		bit           sending;
		ring_result_t expected_q[$];
		int           errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				tx_ring[i] = '0;
				rx_ring[i] = '0;
			end
			tx_wr = 0;
			tx_rd = 0;
			rx_wr = 0;
			rx_rd = 0;
			sending = 1'b0;
			errors = 0;
		endfunction

		function int unsigned advance(int unsigned pos);
			return (pos + 1 >= SLOTS) ? 0 : pos + 1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(op_t code, byte_t value);
			ring_result_t r;
			r = '0;
			case (code)
				OP_HOST_WRITE: begin
					if (advance(tx_wr) == tx_rd) begin
						r.write_failed = 1'b1;
					end else begin
						tx_ring[tx_wr] = value;
						tx_wr = advance(tx_wr);
						if (!sending) begin
							sending = 1'b1;
							r.tx_kick = 1'b1;
						end
					end
				end
				OP_TX_READY: begin
					if (tx_wr != tx_rd) begin
						r.line_out_valid = 1'b1;
						r.line_out_byte = tx_ring[tx_rd];
						tx_rd = advance(tx_rd);
					end else begin
						sending = 1'b0;
					end
				end
				OP_RX_BYTE: begin
					if (advance(rx_wr) == rx_rd) begin
						r.rx_dropped = 1'b1;
					end else begin
						rx_ring[rx_wr] = value;
						rx_wr = advance(rx_wr);
					end
				end
				default: begin
					if (rx_wr != rx_rd) begin
						r.read_valid = 1'b1;
						r.read_byte = rx_ring[rx_rd];
						rx_rd = advance(rx_rd);
					end
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
				errors++;
			end
		endfunction

		function void compare_flag(string name, logic want, logic got);
			if (got !== want) begin
				$error("%s: expected %b, got %b", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ring_result_t got);
			ring_result_t want;
			if (expected_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_flag("write_failed", want.write_failed, got.write_failed);
			compare_flag("tx_kick", want.tx_kick, got.tx_kick);
			compare_flag("line_out_valid", want.line_out_valid, got.line_out_valid);
			compare_field("line_out_byte", want.line_out_byte, got.line_out_byte);
			compare_flag("read_valid", want.read_valid, got.read_valid);
			compare_field("read_byte", want.read_byte, got.read_byte);
			compare_flag("rx_dropped", want.rx_dropped, got.rx_dropped);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         req_valid = 1'b0;
	logic         req_stall;
	op_t          op = OP_HOST_WRITE;
	byte_t        data_byte = '0;
	logic         res_valid;
	logic         res_stall = 1'b0;
	logic         write_failed;
	logic         tx_kick;
	logic         line_out_valid;
	byte_t        line_out_byte;
	logic         read_valid;
	byte_t        read_byte;
	logic         rx_dropped;

	// Set by the sender to ask the receiver for one long hold-off; the
	// receiver marks the hold-off as done once it is over.
	bit           hold_req = 1'b0;
	bit           hold_done = 1'b0;
	int unsigned  idle_cycles = 0;
	ring_result_t observed;

	ring_scoreboard sb = new();

	uart_tx_rx_ring_buffers_unit #(
		.SLOTS(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.data_byte(data_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.write_failed(write_failed),
		.tx_kick(tx_kick),
		.line_out_valid(line_out_valid),
		.line_out_byte(line_out_byte),
		.read_valid(read_valid),
		.read_byte(read_byte),
		.rx_dropped(rx_dropped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offers one request from a falling edge and holds it until a rising edge
	// finds the request channel free. The sender is left at the next falling
	// edge, so a following request keeps valid high without a glitch.
	task automatic send_request(input op_t code, input byte_t value);
		req_valid = 1'b1;
		op = code;
		data_byte = value;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(code, value);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		req_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Stops offering requests until every expected result has come back.
	task automatic drain_results();
		req_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Picks an operation with a weighting that depends on the traffic shape.
	function automatic op_t pick_op(traffic_t shape);
		int unsigned roll;
		roll = $urandom_range(99);
		case (shape)
			TRAFFIC_TX_FILL: begin
				if (roll < 80) return OP_HOST_WRITE;
				if (roll < 90) return OP_TX_READY;
				return (roll < 95) ? OP_RX_BYTE : OP_HOST_READ;
			end
			TRAFFIC_TX_DRAIN: begin
				if (roll < 80) return OP_TX_READY;
				if (roll < 90) return OP_HOST_WRITE;
				return (roll < 95) ? OP_RX_BYTE : OP_HOST_READ;
			end
			TRAFFIC_RX_FILL: begin
				if (roll < 80) return OP_RX_BYTE;
				if (roll < 90) return OP_HOST_READ;
				return (roll < 95) ? OP_HOST_WRITE : OP_TX_READY;
			end
			TRAFFIC_RX_DRAIN: begin
				if (roll < 80) return OP_HOST_READ;
				if (roll < 90) return OP_RX_BYTE;
				return (roll < 95) ? OP_HOST_WRITE : OP_TX_READY;
			end
			default: begin
				return op_t'($urandom_range(3));
			end
		endcase
	endfunction

	// Stimulus: reset, a short directed sequence, then random traffic shaped
	// in segments, with sender bursts and gaps of random length.
	initial begin
		int unsigned sent;
		int unsigned seg_left;
		int unsigned burst_left;
		int unsigned seg_count;
		traffic_t    shape;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Transmit side: the first write kicks the idle transmitter, the second
		// queues behind it. Both pops come out in order, then a ready request
		// on an empty ring sets the transmitter idle, twice in a row. A write
		// after that must kick again. The data byte of a ready request is
		// meaningless and is driven to all ones or to zero.
		send_request(OP_HOST_WRITE, 8'h00);
		send_request(OP_HOST_WRITE, 8'hFF);
		send_request(OP_TX_READY, 8'hFF);
		send_request(OP_TX_READY, 8'h00);
		send_request(OP_TX_READY, 8'hFF);
		send_request(OP_TX_READY, 8'h00);
		send_request(OP_HOST_WRITE, 8'hA5);
		send_request(OP_HOST_WRITE, 8'h5A);
		send_request(OP_TX_READY, 8'h00);
		send_request(OP_TX_READY, 8'h00);
		send_request(OP_TX_READY, 8'h00);

		// Receive side: a read of the empty ring returns zero with read_valid
		// low, then received bytes at both extremes are read back in order,
		// and the ring reads empty again.
		send_request(OP_HOST_READ, 8'hFF);
		send_request(OP_RX_BYTE, 8'h00);
		send_request(OP_RX_BYTE, 8'hFF);
		send_request(OP_RX_BYTE, 8'h5A);
		send_request(OP_HOST_READ, 8'h00);
		send_request(OP_HOST_READ, 8'hFF);
		send_request(OP_HOST_READ, 8'h00);
		send_request(OP_HOST_READ, 8'h00);
		send_request(OP_HOST_READ, 8'hFF);

		// The sender waits here until the unit has answered everything.
		drain_results();
		idle_sender(3);

		sent = 0;
		seg_count = 0;
		burst_left = 0;
		while (sent < RANDOM_ITEMS) begin
			// The first four segments run each ring to full and back to empty,
			// so that the full and empty cases are met early; after that the
			// shapes are random.
			case (seg_count)
				0: shape = TRAFFIC_TX_FILL;
				1: shape = TRAFFIC_RX_FILL;
				2: shape = TRAFFIC_TX_DRAIN;
				3: shape = TRAFFIC_RX_DRAIN;
				default: shape = traffic_t'($urandom_range(4));
			endcase
			seg_left = (seg_count < 4) ? 110 : $urandom_range(40, 120);
			seg_count++;
			while (seg_left > 0 && sent < RANDOM_ITEMS) begin
				if (burst_left == 0) begin
					// A zero gap lets two bursts run together into a longer one.
					idle_sender($urandom_range(3) == 0 ? 0 : $urandom_range(1, 8));
					burst_left = $urandom_range(1, 40);
				end
				// Once in the run the receiver holds off for a long stretch
				// while the sender keeps offering requests back to back, so the
				// unit fills up and stalls its request channel.
				if (sent == 300) begin
					hold_req = 1'b1;
					burst_left = 60;
				end
				// Once in the run the sender pauses until every result is in.
				if (sent == 500) begin
					drain_results();
				end
				send_request(pick_op(shape), byte_t'($urandom_range(255)));
				sent++;
				seg_left--;
				burst_left--;
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Receiver: stretches of random length, each with a stall rate of its
	// own, including stretches with no stall at all. A hold-off request from
	// the sender takes over the channel once, with the stall held high for the whole hold-off.
	initial begin
		int unsigned stretch;
		int unsigned rate;
		int unsigned rates[4];

		rates = '{0, 20, 50, 85};
		forever begin
			if (hold_req && !hold_done) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				stretch = $urandom_range(16, 64);
				rate = rates[$urandom_range(3)];
				for (int i = 0; i < stretch && !(hold_req && !hold_done); i++) begin
					@(negedge clk);
					res_stall = ($urandom_range(99) < rate);
				end
			end
		end
	end

	// Results are taken at the rising edge at which valid is high and the
	// stall is low, and handed to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			observed.write_failed = write_failed;
			observed.tx_kick = tx_kick;
			observed.line_out_valid = line_out_valid;
			observed.line_out_byte = line_out_byte;
			observed.read_valid = read_valid;
			observed.read_byte = read_byte;
			observed.rx_dropped = rx_dropped;
			sb.check_result(observed);
		end
	end

	// Watchdog: any accepted request or result restarts the count.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule

>>> sim.f
rtl/uart_rb_pkg.sv
rtl/uart_tx_rx_ring_buffers_unit.sv
tb/tb_uart_tx_rx_ring_buffers_unit.sv
